// ===== rtl/fmbq_pkg.sv =====
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types and constants for the front/middle/back queue.
// ----------------------------------------------------------------------------
package fmbq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VALUE_W   = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 11;
  // wide enough for any position up to the largest supported depth
  localparam int POS_W     = 17;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT  = 3'd0,
    ACT_PUSH_MIDDLE = 3'd1,
    ACT_PUSH_BACK   = 3'd2,
    ACT_POP_FRONT   = 3'd3,
    ACT_POP_MIDDLE  = 3'd4,
    ACT_POP_BACK    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ===== rtl/fmbq_in_if.sv =====
// ----------------------------------------------------------------------------
// fmbq_in_if
// Command channel: one action and its push value per beat.
// ----------------------------------------------------------------------------
interface fmbq_in_if;
  logic                                valid;
  logic                                ready;
  logic [fmbq_pkg::ACTION_W-1:0]       action;
  logic signed [fmbq_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

// ===== rtl/fmbq_out_if.sv =====
// ----------------------------------------------------------------------------
// fmbq_out_if
// Result channel: popped value, status and fill count per beat.
// ----------------------------------------------------------------------------
interface fmbq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fmbq_pkg::VALUE_W-1:0] pop_value;
  logic [fmbq_pkg::STATUS_W-1:0]       status;
  logic [fmbq_pkg::FILL_W-1:0]         fill_count;

  modport source (output valid, pop_value, status, fill_count, input ready);
  modport sink   (input valid, pop_value, status, fill_count, output ready);
endinterface

// ===== rtl/fmbq_cell.sv =====
// ----------------------------------------------------------------------------
// fmbq_cell
// One storage slot of the row; shifts toward the back on insert and toward
// the front on removal, relative to the broadcast position.
// ----------------------------------------------------------------------------
module fmbq_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  fmbq_pkg::cell_ctl_t              ctl,
  input  logic [fmbq_pkg::VALUE_W-1:0]     ins_value,
  input  logic [fmbq_pkg::VALUE_W-1:0]     prev_value,
  input  logic [fmbq_pkg::VALUE_W-1:0]     next_value,
  output logic [fmbq_pkg::VALUE_W-1:0]     value,
  output logic [fmbq_pkg::VALUE_W-1:0]     tap
);

  localparam logic [fmbq_pkg::POS_W-1:0] IDX = fmbq_pkg::POS_W'(INDEX);

  // slot update
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (ctl.pos == IDX) begin
        value <= ins_value;
      end else if (ctl.pos < IDX) begin
        value <= prev_value;
      end
    end else if (ctl.pop) begin
      if (ctl.pos <= IDX) begin
        value <= next_value;
      end
    end
  end

  // read tap for the removed slot
  assign tap = (ctl.pop && ctl.pos == IDX) ? value : '0;

endmodule

// ===== rtl/fmbq_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmbq_ctrl
// Fill count register, action decode and position selection.
// ----------------------------------------------------------------------------
module fmbq_ctrl #(
  parameter int DEPTH = fmbq_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic [fmbq_pkg::ACTION_W-1:0]         action,
  output fmbq_pkg::cell_ctl_t                   ctl,
  output fmbq_pkg::status_t                     status,
  output logic [$clog2(DEPTH+1)-1:0]            count,
  output logic [$clog2(DEPTH+1)-1:0]            count_next
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic is_full;
  logic is_empty;

  assign is_full  = (count == FULL_CNT);
  assign is_empty = (count == '0);

  // decode action into cell control and status
  always_comb begin
    ctl        = '0;
    status     = fmbq_pkg::ST_DONE;
    count_next = count;
    case (fmbq_pkg::action_t'(action))
      fmbq_pkg::ACT_PUSH_FRONT, fmbq_pkg::ACT_PUSH_MIDDLE, fmbq_pkg::ACT_PUSH_BACK: begin
        if (is_full) begin
          status = fmbq_pkg::ST_FULL;
        end else begin
          ctl.push   = accept;
          count_next = count + CNT_W'(1);
          if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_PUSH_MIDDLE) begin
            ctl.pos = fmbq_pkg::POS_W'(count >> 1);
          end else if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_PUSH_BACK) begin
            ctl.pos = fmbq_pkg::POS_W'(count);
          end
        end
      end
      fmbq_pkg::ACT_POP_FRONT, fmbq_pkg::ACT_POP_MIDDLE, fmbq_pkg::ACT_POP_BACK: begin
        if (is_empty) begin
          status = fmbq_pkg::ST_EMPTY;
        end else begin
          ctl.pop    = accept;
          count_next = count - CNT_W'(1);
          if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_POP_MIDDLE) begin
            ctl.pos = fmbq_pkg::POS_W'((count - CNT_W'(1)) >> 1);
          end else if (fmbq_pkg::action_t'(action) == fmbq_pkg::ACT_POP_BACK) begin
            ctl.pos = fmbq_pkg::POS_W'(count - CNT_W'(1));
          end
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/front_middle_back_queue_core.sv =====
// A result beat is registered and is valid the cycle after its command beat is accepted.
// Throughput: one command per cycle while result beats are taken; every cell of the row
// shifts in the same edge, and the removed value is picked by an OR over the cell taps.
// A full result register holds off new commands until the beat is taken.
// Reset clears the fill count and the result valid; cell contents are not
// cleared and are only read below the fill count.
// ----------------------------------------------------------------------------
// front_middle_back_queue_core
// Ordered store with push and pop at front, middle and back, built as a row
// of shifting cells.
// ----------------------------------------------------------------------------
module front_middle_back_queue_core #(
  parameter int DEPTH = fmbq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fmbq_in_if.sink     cmd,
  fmbq_out_if.source  rsp
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic                          accept;
  fmbq_pkg::cell_ctl_t           ctl;
  fmbq_pkg::status_t             status;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [fmbq_pkg::VALUE_W-1:0]  cell_val [DEPTH];
  logic [fmbq_pkg::VALUE_W-1:0]  cell_tap [DEPTH];
  logic [fmbq_pkg::VALUE_W-1:0]  taken;

  // handshake
  assign cmd.ready = !rsp.valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  fmbq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (cmd.action),
    .ctl        (ctl),
    .status     (status),
    .count      (count),
    .count_next (count_next)
  );

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [fmbq_pkg::VALUE_W-1:0] prev_v;
    logic [fmbq_pkg::VALUE_W-1:0] next_v;
    if (i == 0) begin : g_first
      assign prev_v = cmd.push_value;
    end else begin : g_mid_prev
      assign prev_v = cell_val[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_mid_next
      assign next_v = cell_val[i+1];
    end
    fmbq_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_value  (cmd.push_value),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_val[i]),
      .tap        (cell_tap[i])
    );
  end

  // gather the removed value
  always_comb begin
    taken = '0;
    for (int i = 0; i < DEPTH; i++) begin
      taken = taken | cell_tap[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status     <= status;
      rsp.fill_count <= fmbq_pkg::FILL_W'(count_next);
      if (status == fmbq_pkg::ST_EMPTY) begin
        rsp.pop_value <= '1;
      end else if (ctl.pop) begin
        rsp.pop_value <= taken;
      end else begin
        rsp.pop_value <= '0;
      end
    end
  end

  // checks
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    accept && status == fmbq_pkg::ST_FULL |=> $stable(count))
    else $error("rejected push changed the fill count");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not lower the fill count by one");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> count == $past(count) + CNT_W'(1))
    else $error("push did not raise the fill count by one");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop) && (!(ctl.push || ctl.pop) || accept))
    else $error("cell row driven without an accepted command");

endmodule

// ===== tb/sv/front_middle_back_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// front_middle_back_queue_core_tb
// Self-checking bench for the front/middle/back queue. A short table of
// directed commands covers the empty-store pops, extreme values, both
// middle positions and the undefined action codes. Random traffic follows:
// mixed stretches, then a fill until the store is full and pushes are
// rejected, then a short pop-heavy tail. A shadow copy of the store predicts
// every result, and each result beat is compared field by field.
// ----------------------------------------------------------------------------
module front_middle_back_queue_core_tb;
  import fmbq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;
  localparam int MIXED_ITEMS = 80;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pop_value;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill_count;
  } queue_result_t;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic                      typed;
    queue_result_t             result;
  } dir_row_t;

  // directed commands; a typed result is used where it is obvious
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{ACT_POP_FRONT,   32'sh0000_0000, 1'b1, '{-32'sd1, ST_EMPTY, 11'd0}},
    '{ACT_POP_MIDDLE,  32'sh1234_5678, 1'b1, '{-32'sd1, ST_EMPTY, 11'd0}},
    '{ACT_POP_BACK,    32'shFFFF_FFFF, 1'b1, '{-32'sd1, ST_EMPTY, 11'd0}},
    '{ACT_UNDEF_LO,    32'shFFFF_FFFF, 1'b1, '{32'sd0, ST_DONE, 11'd0}},
    '{ACT_PUSH_BACK,   32'sh7FFF_FFFF, 1'b1, '{32'sd0, ST_DONE, 11'd1}},
    '{ACT_PUSH_FRONT,  32'sh8000_0000, 1'b1, '{32'sd0, ST_DONE, 11'd2}},
    '{ACT_PUSH_MIDDLE, 32'sh0000_0000, 1'b1, '{32'sd0, ST_DONE, 11'd3}},
    '{ACT_PUSH_MIDDLE, 32'shFFFF_FFFF, 1'b1, '{32'sd0, ST_DONE, 11'd4}},
    '{ACT_PUSH_BACK,   32'sh5555_5555, 1'b1, '{32'sd0, ST_DONE, 11'd5}},
    '{ACT_PUSH_FRONT,  32'shAAAA_AAAA, 1'b1, '{32'sd0, ST_DONE, 11'd6}},
    '{ACT_UNDEF_HI,    32'sh0000_007B, 1'b1, '{32'sd0, ST_DONE, 11'd6}},
    '{ACT_POP_MIDDLE,  32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_FRONT,   32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_BACK,    32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_MIDDLE,  32'sh0000_0000, 1'b0, '0},
    '{ACT_PUSH_MIDDLE, 32'sh0000_0001, 1'b0, '0},
    '{ACT_POP_MIDDLE,  32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_MIDDLE,  32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_BACK,    32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_BACK,    32'sh0000_0000, 1'b1, '{-32'sd1, ST_EMPTY, 11'd0}},
    '{ACT_PUSH_MIDDLE, 32'sh0000_002A, 1'b0, '0},
    '{ACT_PUSH_MIDDLE, 32'shDEAD_BEEF, 1'b0, '0},
    '{ACT_POP_MIDDLE,  32'sh0000_0000, 1'b0, '0},
    '{ACT_POP_MIDDLE,  32'sh0000_0000, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fmbq_in_if  cmd_if ();
  fmbq_out_if rsp_if ();

  front_middle_back_queue_core #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  // typed expectation travels with the command beat
  logic          beat_typed;
  queue_result_t beat_typed_result;

  logic signed [VALUE_W-1:0] shadow_store[$];
  queue_result_t             expected_results[$];
  int                        mismatch_count = 0;
  int                        result_beats = 0;
  int                        burst_left = 0;
  int                        sent_level = 0;

  always #10 clk = ~clk;

  // apply one action to the shadow store and return its result
  function automatic queue_result_t predict_queue_action(logic [ACTION_W-1:0] act,
                                                         logic signed [VALUE_W-1:0] val);
    queue_result_t r;
    int pos;
    r.pop_value = '0;
    r.status = ST_DONE;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_MIDDLE, ACT_PUSH_BACK: begin
        if (shadow_store.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (act == ACT_PUSH_FRONT) pos = 0;
          else if (act == ACT_PUSH_MIDDLE) pos = shadow_store.size() / 2;
          else pos = shadow_store.size();
          shadow_store.insert(pos, val);
        end
      end
      ACT_POP_FRONT, ACT_POP_MIDDLE, ACT_POP_BACK: begin
        if (shadow_store.size() == 0) begin
          r.pop_value = -32'sd1;
          r.status = ST_EMPTY;
        end else begin
          if (act == ACT_POP_FRONT) pos = 0;
          else if (act == ACT_POP_MIDDLE) pos = (shadow_store.size() - 1) / 2;
          else pos = shadow_store.size() - 1;
          r.pop_value = shadow_store[pos];
          shadow_store.delete(pos);
        end
      end
      default: ;
    endcase
    r.fill_count = FILL_W'(shadow_store.size());
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               result_beats, field, got, want);
    mismatch_count++;
  endtask

  // random value, with the extremes weighted in
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // push with the given percentage, otherwise pop; rare undefined codes
  function automatic logic [ACTION_W-1:0] pick_action(int push_pct);
    if ($urandom_range(0, 49) == 0)
      return ($urandom_range(0, 1) == 0) ? ACT_UNDEF_LO : ACT_UNDEF_HI;
    if ($urandom_range(0, 99) < push_pct)
      return ACTION_W'($urandom_range(ACT_PUSH_FRONT, ACT_PUSH_BACK));
    return ACTION_W'($urandom_range(ACT_POP_FRONT, ACT_POP_BACK));
  endfunction

  // drive one command beat in bursts, and wait for it to be taken
  task automatic send_cmd(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val,
                          logic typed, queue_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.action     <= act;
    cmd_if.push_value <= val;
    beat_typed        <= typed;
    beat_typed_result <= res;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    burst_left--;
    // coarse fill level, only to steer the stimulus
    if (act <= ACT_PUSH_BACK && sent_level < QDEPTH) sent_level++;
    else if (act >= ACT_POP_FRONT && act <= ACT_POP_BACK && sent_level > 0) sent_level--;
  endtask

  // check result beats, then predict for accepted command beats
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t predicted;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing expected, pop_value", rsp_if.pop_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.pop_value !== want.pop_value)
            report_mismatch("pop_value", rsp_if.pop_value, want.pop_value);
          if (rsp_if.status !== want.status)
            report_mismatch("status", VALUE_W'(rsp_if.status), VALUE_W'(want.status));
          if (rsp_if.fill_count !== want.fill_count)
            report_mismatch("fill_count", VALUE_W'(rsp_if.fill_count),
                            VALUE_W'(want.fill_count));
        end
        result_beats++;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        predicted = predict_queue_action(cmd_if.action, cmd_if.push_value);
        expected_results.push_back(beat_typed ? beat_typed_result : predicted);
      end
    end
  end

  // receiver: ready pattern changes mode every so often
  initial begin
    int mode;
    int span;
    rsp_if.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 150);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= $urandom_range(0, 1);
          2: rsp_if.ready <= (i % 4 == 3);
          default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sent;
    int pct;
    int span;
    cmd_if.valid      <= 1'b0;
    cmd_if.action     <= ACT_PUSH_FRONT;
    cmd_if.push_value <= '0;
    beat_typed        <= 1'b0;
    beat_typed_result <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_cmd(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].value,
               DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);

    // mixed traffic with a drifting push share
    sent = 0;
    while (sent < MIXED_ITEMS) begin
      case ($urandom_range(0, 2))
        0: pct = 25;
        1: pct = 50;
        default: pct = 75;
      endcase
      span = $urandom_range(20, 80);
      repeat (span) send_cmd(pick_action(pct), pick_value(), 1'b0, '0);
      sent += span;
    end

    // fill to the top, then hammer the full store
    while (sent_level < QDEPTH) send_cmd(pick_action(100), pick_value(), 1'b0, '0);
    repeat (40) send_cmd(pick_action(70), pick_value(), 1'b0, '0);

    // short pop-heavy tail from the full store
    repeat (30) send_cmd(pick_action(5), pick_value(), 1'b0, '0);

    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fmbq_pkg.sv
rtl/fmbq_in_if.sv
rtl/fmbq_out_if.sv
rtl/fmbq_cell.sv
rtl/fmbq_ctrl.sv
rtl/front_middle_back_queue_core.sv
tb/sv/front_middle_back_queue_core_tb.sv
